// ===== sv/assert_macros.svh =====
// Assertion helpers shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every rising edge, masked while in reset.
`define SAC_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked on every rising edge, reset included.
`define SAC_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== sv/sac_pkg.sv =====
`default_nettype none

package sac_pkg;

  localparam int IN_NODES  = 10;  // nodes that own coin and draw bits
  localparam int DRAW_W    = 4;
  localparam int SLOT_W    = 10;
  localparam int COUNT_W   = 4;
  localparam int WIN_W     = 4;
  localparam int DELAY_W   = 20;
  localparam int PADDR_W   = 3;
  localparam int PDATA_W   = 32;
  localparam int REG_SEL_BIT = 2;

  localparam logic [SLOT_W-1:0] SLOT_LEN_RST = SLOT_W'(1);
  localparam logic [DRAW_W-1:0] BO_WIN_RST   = DRAW_W'(10);

  typedef enum logic {
    REG_SLOT_LEN = 1'b0,
    REG_BO_WIN   = 1'b1
  } reg_idx_t;

  // Per-tick control fanned out to every lane.
  typedef struct packed {
    logic              active;     // item accepted this cycle
    logic              slot;       // tick is a slot boundary
    logic              success;    // exactly one attempt
    logic              collision;  // two or more attempts
    logic [DRAW_W-1:0] window;     // backoff window, never zero
  } lane_ctl_t;

  typedef struct packed {
    logic               slot_tick;
    logic [IN_NODES-1:0] attempt_mask;
    logic [COUNT_W-1:0] attempt_count;
    logic               success;
    logic               collision;
    logic [WIN_W-1:0]   winner;
    logic [DELAY_W-1:0] delay;
  } result_t;

endpackage

`default_nettype wire

// ===== sv/sac_if.sv =====
`default_nettype none

interface sac_in_if;
  import sac_pkg::*;

  logic                       valid;
  logic                       ready;
  logic [IN_NODES-1:0]        coin_mask;
  logic [IN_NODES*DRAW_W-1:0] backoff_draws;

  modport source (output valid, coin_mask, backoff_draws, input ready);
  modport sink   (input valid, coin_mask, backoff_draws, output ready);
endinterface

interface sac_out_if;
  import sac_pkg::*;

  logic                valid;
  logic                ready;
  logic                slot_tick;
  logic [IN_NODES-1:0] attempt_mask;
  logic [COUNT_W-1:0]  attempt_count;
  logic                success;
  logic                collision;
  logic [WIN_W-1:0]    winner;
  logic [DELAY_W-1:0]  delay;

  modport source (output valid, slot_tick, attempt_mask, attempt_count, success,
                  collision, winner, delay, input ready);
  modport sink   (input valid, slot_tick, attempt_mask, attempt_count, success,
                  collision, winner, delay, output ready);
endinterface

`default_nettype wire

// ===== sv/slotted_aloha_contention.sv =====
// Channel   Dir  Handshake            Payload
// in_if     in   valid/ready          coin_mask[9:0], backoff_draws[39:0]
// out_if    out  valid/ready          slot_tick, attempt_mask, attempt_count,
//                                     success, collision, winner, delay
// cfg (APB) in   psel/penable/pready  reg 0 slot length @0x0, reg 1 backoff window @0x4
//
// One tick per cycle: each item is evaluated in the cycle it is accepted and
// its result sits in the output register on the next cycle.
// The per-node lanes, popcount and age select form one combinational pass.
// The input stalls only while the output register is full and not taken.
// rst_n is synchronous: lanes, time, phase and output valid clear; config
// returns to a slot length of 1 and a backoff window of 10.
`default_nettype none

module slotted_aloha_contention #(
  parameter int NODE_COUNT = 10,
  parameter int TIME_BITS  = 20
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  sac_in_if.sink                             in_if,
  sac_out_if.source                          out_if,
  input  wire logic                          psel,
  input  wire logic                          penable,
  input  wire logic                          pwrite,
  input  wire logic [sac_pkg::PADDR_W-1:0]   paddr,
  input  wire logic [sac_pkg::PDATA_W-1:0]   pwdata,
  output logic [sac_pkg::PDATA_W-1:0]        prdata,
  output logic                               pready
);
  import sac_pkg::*;

  // ---------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------
  logic [SLOT_W-1:0] slot_len_r;
  logic [DRAW_W-1:0] bo_win_r;
  logic              cfg_wr;
  reg_idx_t          reg_idx;

  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite;
  assign reg_idx = reg_idx_t'(paddr[REG_SEL_BIT]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      slot_len_r <= SLOT_LEN_RST;
      bo_win_r   <= BO_WIN_RST;
    end else if (cfg_wr) begin
      unique case (reg_idx)
        REG_SLOT_LEN: slot_len_r <= pwdata[SLOT_W-1:0];
        REG_BO_WIN:   bo_win_r   <= pwdata[DRAW_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_SLOT_LEN: prdata = PDATA_W'(slot_len_r);
      REG_BO_WIN:   prdata = PDATA_W'(bo_win_r);
      default:      prdata = '0;
    endcase
  end

  // ---------------------------------------------------------------
  // Handshake and tick bookkeeping
  // ---------------------------------------------------------------
  logic                 out_valid_r, out_valid_nxt;
  logic                 in_ready;
  logic                 accept;
  logic [SLOT_W-1:0]    phase_r, phase_nxt;
  logic [SLOT_W:0]      phase_inc;
  logic [SLOT_W-1:0]    period;
  logic [TIME_BITS-1:0] now_r;
  logic                 is_slot;

  assign in_ready    = !out_valid_r || out_if.ready;
  assign in_if.ready = in_ready;
  assign accept      = in_if.valid && in_ready;

  assign period    = (slot_len_r == '0) ? SLOT_W'(1) : slot_len_r;
  assign is_slot   = (phase_r == '0);
  assign phase_inc = {1'b0, phase_r} + (SLOT_W + 1)'(1);
  // wraps on reaching the period, also when the period shrank below the phase
  assign phase_nxt = (phase_inc >= {1'b0, period}) ? '0 : phase_inc[SLOT_W-1:0];

  assign out_valid_nxt = accept || (out_valid_r && !out_if.ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      phase_r     <= '0;
      now_r       <= '0;
    end else begin
      out_valid_r <= out_valid_nxt;
      if (accept) begin
        phase_r <= phase_nxt;
        now_r   <= now_r + TIME_BITS'(1);
      end
    end
  end

  // ---------------------------------------------------------------
  // Node lanes: one per node, each holds backoff and packet birth time
  // ---------------------------------------------------------------
  lane_ctl_t             ctl;
  logic [NODE_COUNT-1:0] attempt;
  logic [TIME_BITS-1:0]  age [NODE_COUNT];
  logic [COUNT_W-1:0]    count;
  logic                  success;
  logic                  collision;
  logic [WIN_W-1:0]      winner;
  logic [TIME_BITS-1:0]  merge_delay;

  assign ctl.active    = accept;
  assign ctl.slot      = is_slot;
  assign ctl.success   = success;
  assign ctl.collision = collision;
  assign ctl.window    = (bo_win_r == '0) ? DRAW_W'(1) : bo_win_r;

  for (genvar g = 0; g < NODE_COUNT; g++) begin : g_lane
    logic              coin;
    logic [DRAW_W-1:0] draw;

    // nodes beyond the input row never see a coin or a draw
    if (g < IN_NODES) begin : g_fed
      assign coin = in_if.coin_mask[g];
      assign draw = in_if.backoff_draws[g*DRAW_W +: DRAW_W];
    end else begin : g_idle
      assign coin = 1'b0;
      assign draw = '0;
    end

    sac_lane #(
      .TIME_BITS (TIME_BITS)
    ) u_lane (
      .clk     (clk),
      .rst_n   (rst_n),
      .ctl     (ctl),
      .coin    (coin),
      .draw    (draw),
      .now     (now_r),
      .attempt (attempt[g]),
      .age     (age[g])
    );
  end

  // ---------------------------------------------------------------
  // Merge: attempt count, outcome, winner and its packet age
  // ---------------------------------------------------------------
  sac_merge #(
    .NODE_COUNT (NODE_COUNT),
    .TIME_BITS  (TIME_BITS)
  ) u_merge (
    .attempt   (attempt),
    .age       (age),
    .count     (count),
    .success   (success),
    .collision (collision),
    .winner    (winner),
    .delay     (merge_delay)
  );

  // ---------------------------------------------------------------
  // Output register
  // ---------------------------------------------------------------
  localparam int WIDE_W = TIME_BITS + DELAY_W;

  result_t           res_nxt, res_r;
  logic [WIDE_W-1:0] delay_wide;

  assign delay_wide = WIDE_W'(merge_delay);

  // attempts only happen on slot ticks, so off-slot results come out all zero
  always_comb begin
    res_nxt.slot_tick     = is_slot;
    res_nxt.attempt_mask  = IN_NODES'(attempt);
    res_nxt.attempt_count = count;
    res_nxt.success       = success;
    res_nxt.collision     = collision;
    res_nxt.winner        = winner;
    res_nxt.delay         = delay_wide[DELAY_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      res_r <= res_nxt;
    end
  end

  assign out_if.valid         = out_valid_r;
  assign out_if.slot_tick     = res_r.slot_tick;
  assign out_if.attempt_mask  = res_r.attempt_mask;
  assign out_if.attempt_count = res_r.attempt_count;
  assign out_if.success       = res_r.success;
  assign out_if.collision     = res_r.collision;
  assign out_if.winner        = res_r.winner;
  assign out_if.delay         = res_r.delay;

  // ---------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------
  logic out_win;
  logic out_off;

  assign out_win = out_valid_r && res_r.success;
  assign out_off = out_valid_r && !res_r.slot_tick;

`include "assert_macros.svh"

  `SAC_ASSERT(a_accept_fills_out, accept |=> out_valid_r, "accepted item produced no result")
  `SAC_ASSERT(a_outcome_excl, !(out_win && res_r.collision), "success and collision together")
  `SAC_ASSERT(a_success_single, out_win |-> $onehot(res_r.attempt_mask), "lone winner expected")
  `SAC_ASSERT(a_offslot_quiet, out_off |-> !(|res_r.attempt_mask), "attempt off a slot")
  `SAC_ASSERT_ALWAYS(a_reset_idle, !rst_n |=> !out_valid_r, "result valid after reset")

endmodule

`default_nettype wire

// ===== sv/sac_lane.sv =====
`default_nettype none

module sac_lane #(
  parameter int TIME_BITS = 20
) (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire sac_pkg::lane_ctl_t           ctl,
  input  wire logic                         coin,
  input  wire logic [sac_pkg::DRAW_W-1:0]   draw,
  input  wire logic [TIME_BITS-1:0]         now,
  output logic                              attempt,
  output logic [TIME_BITS-1:0]              age
);
  import sac_pkg::*;

  logic [DRAW_W-1:0]    backoff_r, backoff_nxt;
  logic [TIME_BITS-1:0] birth_r, birth_nxt;
  logic [DRAW_W-1:0]    clamped;

  assign attempt = ctl.slot && (backoff_r == '0) && coin;
  assign age     = now - birth_r;
  assign clamped = (draw >= ctl.window) ? ctl.window - DRAW_W'(1) : draw;

  always_comb begin
    backoff_nxt = backoff_r;
    birth_nxt   = birth_r;
    if (ctl.active && ctl.slot) begin
      if (attempt && ctl.collision) begin
        backoff_nxt = clamped;
      end
      if (attempt && ctl.success) begin
        birth_nxt = now;
      end
      // countdown follows the reload in the same slot
      if (backoff_nxt != '0) begin
        backoff_nxt = backoff_nxt - DRAW_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      backoff_r <= '0;
      birth_r   <= '0;
    end else begin
      backoff_r <= backoff_nxt;
      birth_r   <= birth_nxt;
    end
  end

endmodule

`default_nettype wire

// ===== sv/sac_merge.sv =====
`default_nettype none

module sac_merge #(
  parameter int NODE_COUNT = 10,
  parameter int TIME_BITS  = 20
) (
  input  wire logic [NODE_COUNT-1:0]      attempt,
  input  wire logic [TIME_BITS-1:0]       age [NODE_COUNT],
  output logic [sac_pkg::COUNT_W-1:0]     count,
  output logic                            success,
  output logic                            collision,
  output logic [sac_pkg::WIN_W-1:0]       winner,
  output logic [TIME_BITS-1:0]            delay
);
  import sac_pkg::*;

  localparam int CNT_W = $clog2(NODE_COUNT + 1);

  logic [CNT_W-1:0]     cnt;
  logic [WIN_W-1:0]     idx_or;
  logic [TIME_BITS-1:0] age_or;

  // With a single attempt the OR of indices and ages picks out that node.
  always_comb begin
    cnt    = '0;
    idx_or = '0;
    age_or = '0;
    for (int i = 0; i < NODE_COUNT; i++) begin
      cnt = cnt + CNT_W'(attempt[i]);
      if (attempt[i]) begin
        idx_or = idx_or | WIN_W'(i);
        age_or = age_or | age[i];
      end
    end
  end

  assign success   = (cnt == CNT_W'(1));
  assign collision = (cnt > CNT_W'(1));
  assign count     = COUNT_W'(cnt);
  assign winner    = success ? idx_or : '0;
  assign delay     = success ? age_or : '0;

endmodule

`default_nettype wire

// ===== sim/testbench.sv =====
`default_nettype none

// Testbench top for the slotted-ALOHA contention block.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import sac_pkg::*;

  localparam int NODES     = 10;
  localparam int TIME_BITS = 20;
  localparam int DRAW_BITS = IN_NODES * DRAW_W;

  // ---------------------------------------------------------------------------
  // Channel model plus the list of results still owed by the block.
  // Every accepted tick yields exactly one result, in tick order.
  // ---------------------------------------------------------------------------
  class channel_scoreboard;
    logic [SLOT_W-1:0]    slot_period;
    logic [DRAW_W-1:0]    backoff_window;
    logic [DRAW_W-1:0]    backoff_cnt [IN_NODES];
    logic [TIME_BITS-1:0] birth_tick [IN_NODES];
    logic [TIME_BITS-1:0] tick_now;
    logic [SLOT_W-1:0]    slot_pos;
    result_t              slot_reports [$];
    int                   failures;

    function new();
      slot_period    = SLOT_LEN_RST;
      backoff_window = BO_WIN_RST;
      foreach (backoff_cnt[i]) begin
        backoff_cnt[i] = '0;
        birth_tick[i]  = '0;
      end
      tick_now = '0;
      slot_pos = '0;
      failures = 0;
    endfunction

    function void set_reg(reg_idx_t idx, logic [PDATA_W-1:0] value);
      case (idx)
        REG_SLOT_LEN: slot_period    = value[SLOT_W-1:0];
        REG_BO_WIN:   backoff_window = value[DRAW_W-1:0];
        default: ;
      endcase
    endfunction

    function int pending();
      return slot_reports.size();
    endfunction

    // Advance the model by one accepted tick and queue its result.
    function void note_tick(logic [IN_NODES-1:0] coins, logic [DRAW_BITS-1:0] draws);
      result_t           r;
      logic [DRAW_W-1:0] window;
      logic [DRAW_W-1:0] d;
      int                period;
      int                attempts;
      int                last;
      int                nxt;
      r        = '0;
      window   = (backoff_window == 0) ? DRAW_W'(1) : backoff_window;
      period   = (slot_period == 0) ? 1 : int'(slot_period);
      attempts = 0;
      last     = 0;
      if (slot_pos == 0) begin
        r.slot_tick = 1'b1;
        for (int i = 0; i < IN_NODES; i++) begin
          if (backoff_cnt[i] == 0 && coins[i]) begin
            r.attempt_mask[i] = 1'b1;
            attempts++;
            last = i;
          end
        end
        if (attempts == 1) begin
          r.success = 1'b1;
          r.winner  = WIN_W'(last);
          r.delay   = DELAY_W'(tick_now - birth_tick[last]);
          birth_tick[last] = tick_now;
        end else if (attempts > 1) begin
          r.collision = 1'b1;
          for (int i = 0; i < IN_NODES; i++) begin
            if (r.attempt_mask[i]) begin
              d = draws[i*DRAW_W +: DRAW_W];
              if (d >= window) d = window - 1'b1;
              backoff_cnt[i] = d;
            end
          end
        end
        for (int i = 0; i < IN_NODES; i++)
          if (backoff_cnt[i] != 0) backoff_cnt[i]--;
        r.attempt_count = COUNT_W'(attempts);
      end
      slot_reports.push_back(r);
      // phase wraps on reaching the period, also when the period shrank under it
      nxt = int'(slot_pos) + 1;
      if (nxt >= period) nxt = 0;
      slot_pos = SLOT_W'(nxt);
      tick_now = tick_now + 1'b1;
    endfunction

    function void check_result(result_t got);
      result_t exp;
      bit      ok;
      if (slot_reports.size() == 0) begin
        failures++;
        if (failures <= 10)
          $display("%0t: result with no tick pending: %h", $realtime, got);
        return;
      end
      exp = slot_reports.pop_front();
      ok  = got.slot_tick     === exp.slot_tick
         && got.attempt_mask  === exp.attempt_mask
         && got.attempt_count === exp.attempt_count
         && got.success       === exp.success
         && got.collision     === exp.collision
         && got.winner        === exp.winner
         && got.delay         === exp.delay;
      if (!ok) begin
        failures++;
        if (failures <= 10)
          $display("%0t: mismatch exp %b %h %0d %b %b %0d %0d got %b %h %0d %b %b %0d %0d",
                   $realtime,
                   exp.slot_tick, exp.attempt_mask, exp.attempt_count, exp.success,
                   exp.collision, exp.winner, exp.delay,
                   got.slot_tick, got.attempt_mask, got.attempt_count, got.success,
                   got.collision, got.winner, got.delay);
      end
    endfunction
  endclass

  // ---------------------------------------------------------------------------
  // Clock, reset, channels and the block
  // ---------------------------------------------------------------------------
  logic                clk;
  logic                rst_n;
  logic                psel;
  logic                penable;
  logic                pwrite;
  logic [PADDR_W-1:0]  paddr;
  logic [PDATA_W-1:0]  pwdata;
  logic [PDATA_W-1:0]  prdata;
  logic                pready;

  sac_in_if  tick_bus ();
  sac_out_if result_bus ();

  channel_scoreboard sb = new();

  // Idle knobs, set per phase by the main sequence.
  bit tx_idle;
  bit rx_idle;
  int rx_hold;

  always begin
    clk = 1'b1;
    #6;
    clk = 1'b0;
    #6;
  end

  slotted_aloha_contention #(
    .NODE_COUNT (NODES),
    .TIME_BITS  (TIME_BITS)
  ) i_dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_if   (tick_bus),
    .out_if  (result_bus),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  // ---------------------------------------------------------------------------
  // Drivers. All called at a rising edge; inputs change by NBA only.
  // ---------------------------------------------------------------------------

  // APB write: setup cycle, then access until pready.
  task automatic write_reg(input reg_idx_t idx, input logic [PDATA_W-1:0] value);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    sb.set_reg(idx, value);
  endtask

  // Offer one tick item, optionally after a random gap, and wait for it
  // to be taken. Valid only drops when a gap is actually drawn.
  task automatic send_tick(input logic [IN_NODES-1:0] coins,
                           input logic [DRAW_BITS-1:0] draws);
    int gap;
    gap = tx_idle ? $urandom_range(0, 9) : 0;
    if (gap > 0) begin
      tick_bus.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    tick_bus.valid         <= 1'b1;
    tick_bus.coin_mask     <= coins;
    tick_bus.backoff_draws <= draws;
    do @(posedge clk); while (!tick_bus.ready);
    sb.note_tick(coins, draws);
  endtask

  // Block is idle once every result is out; the extra wait covers the
  // single register stage.
  task automatic settle();
    tick_bus.valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (2) @(posedge clk);
  endtask

  // Random tick: single or sparse coin masks so that successes are
  // frequent, plus fully random, all-attempt and empty masks.
  task automatic random_tick();
    logic [IN_NODES-1:0]  coins;
    logic [DRAW_BITS-1:0] draws;
    case ($urandom_range(0, 4))
      0:       coins = IN_NODES'(1) << $urandom_range(0, IN_NODES - 1);
      1:       coins = IN_NODES'($urandom) & IN_NODES'($urandom);
      2:       coins = '1;
      3:       coins = '0;
      default: coins = IN_NODES'($urandom);
    endcase
    draws = {8'($urandom), 32'($urandom)};
    send_tick(coins, draws);
  endtask

  task automatic run_phase(input logic [PDATA_W-1:0] period,
                           input logic [PDATA_W-1:0] window,
                           input int items, input bit idle_tx, input bit idle_rx,
                           input int hold);
    settle();
    write_reg(REG_SLOT_LEN, period);
    write_reg(REG_BO_WIN, window);
    tx_idle = idle_tx;
    rx_idle = idle_rx;
    rx_hold = hold;
    repeat (items) random_tick();
  endtask

  // ---------------------------------------------------------------------------
  // Result sink: random stall after each item while rx_idle is set, plus a long counted
  // hold-off when rx_hold is loaded, to back the block up into its input.
  // ---------------------------------------------------------------------------
  initial begin : result_sink
    int      stall;
    result_t got;
    stall = 0;
    do @(posedge clk); while (!rst_n);
    forever begin
      @(posedge clk);
      if (result_bus.valid && result_bus.ready) begin
        got.slot_tick     = result_bus.slot_tick;
        got.attempt_mask  = result_bus.attempt_mask;
        got.attempt_count = result_bus.attempt_count;
        got.success       = result_bus.success;
        got.collision     = result_bus.collision;
        got.winner        = result_bus.winner;
        got.delay         = result_bus.delay;
        sb.check_result(got);
        stall = rx_idle ? $urandom_range(0, 9) : 0;
      end
      if (rx_hold > 0) begin
        result_bus.ready <= 1'b0;
        rx_hold--;
      end else if (stall > 0) begin
        result_bus.ready <= 1'b0;
        stall--;
      end else begin
        result_bus.ready <= 1'b1;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------
  initial begin : main_seq
    int guard;
    rst_n                  <= 1'b0;
    tick_bus.valid         <= 1'b0;
    tick_bus.coin_mask     <= '0;
    tick_bus.backoff_draws <= '0;
    result_bus.ready       <= 1'b0;
    psel                   <= 1'b0;
    penable                <= 1'b0;
    pwrite                 <= 1'b0;
    paddr                  <= '0;
    pwdata                 <= '0;
    tx_idle = 1'b0;
    rx_idle = 1'b0;
    rx_hold = 0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: window of one, so colliders retry at once.
    write_reg(REG_SLOT_LEN, 1);
    write_reg(REG_BO_WIN, 1);
    send_tick('0, '0);                         // slot with no attempt
    send_tick(10'h001, '0);                    // lone attempt, lowest node
    send_tick(10'h200, '0);                    // lone attempt, highest node
    send_tick('1, '1);                         // all attempt, draws clamped to 0
    send_tick('1, '0);                         // same nodes collide again
    send_tick(10'h001, '1);                    // node 0 wins, delay since its last win

    // Zero window behaves like a window of one.
    settle();
    write_reg(REG_BO_WIN, 0);
    send_tick('1, '1);
    send_tick(10'h003, '1);                    // two-way collision

    // Widest window: every collider parks at the top of the window.
    settle();
    write_reg(REG_BO_WIN, 15);
    send_tick('1, '1);
    send_tick('1, '0);                         // all still backing off
    send_tick('1, '0);
    send_tick(10'h155, 40'h0123456789);        // mixed draws below the clamp

    // Zero slot length means every tick is a slot.
    settle();
    write_reg(REG_SLOT_LEN, 0);
    repeat (4) send_tick('1, 40'h0F0F0F0F0F);
    send_tick(10'h2AA, 40'hEDCBA98765);

    // Slots every other tick: odd ticks report all zero.
    settle();
    write_reg(REG_SLOT_LEN, 2);
    send_tick('1, '1);
    send_tick('1, '1);                         // no slot, nothing changes
    send_tick(10'h200, '0);

    // Random phases across the register ranges.
    run_phase(1,    10, 100, 1'b1, 1'b1, 0);
    run_phase(2,    15, 100, 1'b0, 1'b0, 0);
    run_phase(1,     0,  80, 1'b1, 1'b0, 0);
    run_phase(3,     1, 100, 1'b0, 1'b1, 0);
    // Receiver holds off while the sender keeps offering.
    run_phase(0,     4, 100, 1'b0, 1'b1, 60);
    // Longest period, then shrink it below the current phase.
    run_phase(1023,  7,  40, 1'b1, 1'b1, 0);
    run_phase(2,    10, 100, 1'b1, 1'b1, 0);
    run_phase(5,    15,  60, 1'b0, 1'b0, 0);
    run_phase(1,     2,  60, 1'b1, 1'b1, 0);
    tick_bus.valid <= 1'b0;

    // Drain, then wait for any stray result.
    guard = 0;
    while (sb.pending() != 0 && guard < 2000) begin
      @(posedge clk);
      guard++;
    end
    repeat (5) @(posedge clk);

    if (sb.failures == 0 && sb.pending() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  // Hard stop well beyond the slowest legal run.
  initial begin : watchdog
    #2_000_000;
    $display("TB_ERROR");
    $finish;
  end

endmodule

`default_nettype wire
